// ===== rtl/core/kmdr_pkg.sv =====
// ----------------------------------------------------------------------------
// Key matrix debounce package
// Shared item types, scan control struct and fixed widths for the key matrix
// debounce and report block.
// ----------------------------------------------------------------------------
`default_nettype none

package kmdr_pkg;

    localparam int unsigned RAW_W      = 20;
    localparam int unsigned TIME_W     = 32;
    localparam int unsigned DEB_W      = 16;
    localparam int unsigned SLOT_W     = 5;
    localparam int unsigned OUT_SLOTS  = 6;
    // Wide enough for the rank of any key in a matrix of up to 128 keys.
    localparam int unsigned RANK_W     = 7;

    localparam logic [DEB_W-1:0] DEBOUNCE_RESET = 16'd10;

    typedef struct packed {
        logic [RAW_W-1:0]  raw_down;
        logic [TIME_W-1:0] now_ms;
    } kmdr_in_t;

    typedef struct packed {
        logic [RAW_W-1:0]  debounced_down;
        logic              any_down;
        logic [SLOT_W-1:0] slot_0;
        logic [SLOT_W-1:0] slot_1;
        logic [SLOT_W-1:0] slot_2;
        logic [SLOT_W-1:0] slot_3;
        logic [SLOT_W-1:0] slot_4;
        logic [SLOT_W-1:0] slot_5;
    } kmdr_out_t;

    // Per-scan control that every key cell sees.
    typedef struct packed {
        logic              update;
        logic [TIME_W-1:0] now_ms;
        logic [DEB_W-1:0]  debounce_ms;
    } kmdr_scan_t;

endpackage

`default_nettype wire

// ===== rtl/core/kmdr_key_cell.sv =====
// ----------------------------------------------------------------------------
// Key debounce cell
// Holds one key's debounced level and the time of its last accepted change.
// ----------------------------------------------------------------------------
`default_nettype none

module kmdr_key_cell (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire kmdr_pkg::kmdr_scan_t scan,
    input  wire logic                raw_level,
    output logic                     pressed_next
);
    import kmdr_pkg::*;

    logic              pressed_reg;
    logic [TIME_W-1:0] stamp_reg;
    logic [TIME_W-1:0] held;
    logic              accept;

    // A new level is taken only when the time since the last accepted change is longer than the window.
    assign held   = scan.now_ms - stamp_reg;
    assign accept = (raw_level != pressed_reg) &&
                    (held > {{(TIME_W-DEB_W){1'b0}}, scan.debounce_ms});
    assign pressed_next = accept ? raw_level : pressed_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pressed_reg <= 1'b0;
            stamp_reg   <= '0;
        end else if (scan.update && accept) begin
            pressed_reg <= raw_level;
            stamp_reg   <= scan.now_ms;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/kmdr_report.sv =====
// ----------------------------------------------------------------------------
// Key report builder
// Builds the bitmap, any-key flag and slot report from the debounced levels.
// ----------------------------------------------------------------------------
`default_nettype none

module kmdr_report #(
    parameter int unsigned NUM_KEYS     = 20,
    parameter int unsigned REPORT_SLOTS = 6
) (
    input  wire logic [NUM_KEYS-1:0] pressed,
    output kmdr_pkg::kmdr_out_t      result
);
    import kmdr_pkg::*;

    logic [SLOT_W-1:0] slot_val [OUT_SLOTS];
    logic [RAW_W-1:0]  bitmap;

    // Each key finds its rank among the pressed keys below it; a pressed key
    // whose rank is j fills slot j, so the slots come out in index order.
    always_comb begin
        logic [NUM_KEYS-1:0] below;
        logic [RANK_W-1:0]   rank;
        for (int j = 0; j < OUT_SLOTS; j++) begin
            slot_val[j] = '0;
        end
        for (int k = 0; k < NUM_KEYS; k++) begin
            for (int i = 0; i < NUM_KEYS; i++) begin
                below[i] = (i < k);
            end
            rank = RANK_W'($countones(pressed & below));
            for (int j = 0; j < OUT_SLOTS; j++) begin
                if ((j < REPORT_SLOTS) && pressed[k] && (rank == RANK_W'(j))) begin
                    slot_val[j] = slot_val[j] | SLOT_W'(k + 1);
                end
            end
        end
    end

    always_comb begin
        bitmap = '0;
        for (int k = 0; k < NUM_KEYS; k++) begin
            if (k < RAW_W) begin
                bitmap[k] = pressed[k];
            end
        end
    end

    always_comb begin
        result.debounced_down = bitmap;
        result.any_down       = |pressed;
        result.slot_0         = slot_val[0];
        result.slot_1         = slot_val[1];
        result.slot_2         = slot_val[2];
        result.slot_3         = slot_val[3];
        result.slot_4         = slot_val[4];
        result.slot_5         = slot_val[5];
    end

endmodule

`default_nettype wire

// ===== rtl/core/key_matrix_debounce_report_top.sv =====
// ----------------------------------------------------------------------------
// Key matrix debounce and report, top level
// Debounces one full matrix scan per item and returns the debounced bitmap,
// an any-key flag and a six-slot report of the pressed keys.
// ----------------------------------------------------------------------------
// An accepted item waits in the input register, then moves to the result register.
// Throughput: one item per cycle while m_ready does not stall the result side; the
// per-key debounce cells and the report builder sit between those two registers.
// Reset: synchronous active-low aresetn releases all keys, zeroes every
// change time, sets debounce_ms to 10 and empties both registers.
`default_nettype none

module key_matrix_debounce_report_top #(
    parameter int unsigned NUM_ROWS     = 5,
    parameter int unsigned NUM_COLS     = 4,
    parameter int unsigned REPORT_SLOTS = 6
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // Scan input channel.
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire kmdr_pkg::kmdr_in_t   s_data,
    // Result channel.
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output kmdr_pkg::kmdr_out_t       m_data,
    // Configuration write channel for debounce_ms.
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [15:0]          cfg_data
);
    import kmdr_pkg::*;

    localparam int unsigned NUM_KEYS = NUM_ROWS * NUM_COLS;

    kmdr_in_t          in_reg;
    logic              in_valid_reg;
    kmdr_out_t         out_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [DEB_W-1:0]  debounce_reg;
    logic              advance;
    kmdr_scan_t        scan;
    logic [NUM_KEYS-1:0] pressed_next;
    kmdr_out_t         result;

    // The held item moves into the result register whenever that register is
    // empty or its item is being taken in the same cycle. The input register
    // accepts a new item in that same cycle, so scans flow back to back.
    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg <= DEBOUNCE_RESET;
        end else if (cfg_valid && cfg_ready) begin
            debounce_reg <= cfg_data;
        end
    end

    // Key state commits only when the item moves on, so each scan sees the
    // state that the previous scan left behind.
    assign scan.update      = advance;
    assign scan.now_ms      = in_reg.now_ms;
    assign scan.debounce_ms = debounce_reg;

    genvar k;
    generate
        for (k = 0; k < NUM_KEYS; k++) begin : g_key
            logic raw_level;
            // Keys past the raw field width always read as released.
            if (k < RAW_W) begin : g_raw
                assign raw_level = in_reg.raw_down[k];
            end else begin : g_none
                assign raw_level = 1'b0;
            end

            kmdr_key_cell u_cell (
                .aclk         (aclk),
                .aresetn      (aresetn),
                .scan         (scan),
                .raw_level    (raw_level),
                .pressed_next (pressed_next[k])
            );
        end
    endgenerate

    kmdr_report #(
        .NUM_KEYS     (NUM_KEYS),
        .REPORT_SLOTS (REPORT_SLOTS)
    ) u_report (
        .pressed (pressed_next),
        .result  (result)
    );

    always_comb begin
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// Key matrix debounce and report testbench
// Feeds whole matrix scans with chosen time stamps into the debounce block,
// keeps its own copy of every key's debounced level and change time, and
// checks each returned report field by field under random idling, a long
// output stall and several debounce settings.
// ----------------------------------------------------------------------------

module testbench;

    import kmdr_pkg::*;

    // Matrix geometry matches the defaults of the block.
    localparam int unsigned NUM_ROWS     = 5;
    localparam int unsigned NUM_COLS     = 4;
    localparam int unsigned NUM_KEYS     = NUM_ROWS * NUM_COLS;
    localparam int unsigned REPORT_SLOTS = 6;

    // Percentage of cycles in which either side idles when idling is on.
    localparam int unsigned IDLE_PCT    = 18;
    // Only the first few mismatches are printed; the rest are counted.
    localparam int unsigned MAX_SHOWN   = 10;
    // Bound on the run length; a correct run stays below it.
    localparam int unsigned CYCLE_LIMIT = 200000;
    // Length of the receiver hold-off that fills the block.
    localparam int unsigned HOLD_CYCLES = 300;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    kmdr_in_t  s_data;
    logic      m_valid;
    logic      m_ready;
    kmdr_out_t m_data;
    logic      cfg_valid;
    logic      cfg_ready;
    logic [DEB_W-1:0] cfg_data;

    // Own copy of the block's state: debounced level and time of the last
    // accepted change per key, plus the debounce register.
    logic             key_down   [NUM_KEYS];
    logic [TIME_W-1:0] changed_at [NUM_KEYS];
    logic [DEB_W-1:0] debounce_setting;

    // Reports predicted for accepted scans, oldest first.
    kmdr_out_t pending_reports [$];

    // Last time stamp sent and the raw level that random bouncing works on.
    logic [TIME_W-1:0] clock_ms;
    logic [RAW_W-1:0]  raw_level;

    // When set, neither side idles; a nonzero hold keeps m_ready low.
    bit          no_idle;
    int unsigned ready_hold;

    int unsigned failures;
    int unsigned scans_sent;
    int unsigned reports_checked;
    int unsigned cycle_count;
    logic [DEB_W-1:0] steady_deb;

    key_matrix_debounce_report_top #(
        .NUM_ROWS     (NUM_ROWS),
        .NUM_COLS     (NUM_COLS),
        .REPORT_SLOTS (REPORT_SLOTS)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // 20-unit clock period, low half first.
    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    // Debounce one scan against the local key state and build the report
    // the block should return for it. The state is updated as a side effect.
    function automatic kmdr_out_t debounce_scan(input kmdr_in_t scan);
        logic [TIME_W-1:0] held;
        logic [SLOT_W-1:0] slot_val [OUT_SLOTS];
        int unsigned       filled;
        kmdr_out_t         rep;
        filled = 0;
        rep    = '0;
        for (int s = 0; s < OUT_SLOTS; s++) begin
            slot_val[s] = '0;
        end
        for (int k = 0; k < NUM_KEYS; k++) begin
            // A new level only sticks once the time since the key's last accepted change
            // is strictly longer than the debounce time; the difference wraps at 32 bits.
            if (scan.raw_down[k] != key_down[k]) begin
                held = scan.now_ms - changed_at[k];
                if (held > {{(TIME_W-DEB_W){1'b0}}, debounce_setting}) begin
                    key_down[k]   = scan.raw_down[k];
                    changed_at[k] = scan.now_ms;
                end
            end
            if (key_down[k]) begin
                rep.debounced_down[k] = 1'b1;
                rep.any_down          = 1'b1;
                if (filled < REPORT_SLOTS) begin
                    slot_val[filled] = SLOT_W'(k + 1);
                    filled++;
                end
            end
        end
        rep.slot_0 = slot_val[0];
        rep.slot_1 = slot_val[1];
        rep.slot_2 = slot_val[2];
        rep.slot_3 = slot_val[3];
        rep.slot_4 = slot_val[4];
        rep.slot_5 = slot_val[5];
        return rep;
    endfunction

    task automatic compare_field(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            failures++;
            if (failures <= MAX_SHOWN) begin
                $display("Mismatch in report %0d, %s: expected %0h, got %0h",
                         reports_checked, field, want, got);
            end
        end
    endtask

    // Offer one scan, possibly after a random pause, and hold it until the
    // block takes it. The expected report is worked out at acceptance.
    task automatic send_scan(input logic [RAW_W-1:0] raw, input logic [TIME_W-1:0] stamp);
        kmdr_in_t scan;
        scan.raw_down = raw;
        scan.now_ms   = stamp;
        // Each extra cycle of idling is drawn on its own, with a chance of
        // IDLE_PCT percent.
        while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= scan;
        do @(posedge aclk); while (!s_ready);
        pending_reports.push_back(debounce_scan(scan));
        scans_sent++;
        clock_ms = stamp;
    endtask

    // Stop offering scans and wait until every predicted report has come.
    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_reports.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // The register is only written while nothing is in flight.
    task automatic write_debounce(input logic [DEB_W-1:0] value);
        wait_drained();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        debounce_setting = value;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // After reset every change time is zero and the debounce time is 10, so
    // a press at time 10 is still too early and one at time 11 sticks.
    task automatic test_reset_defaults();
        send_scan(20'hFFFFF, 32'd0);
        send_scan(20'hFFFFF, 32'd10);
        send_scan(20'hFFFFF, 32'd11);
        send_scan(20'h00000, 32'd21);
        send_scan(20'h00000, 32'd22);
    endtask

    // Threshold edges at both ends of the debounce range, sparse and full
    // reports, the top key index and time stamps that wrap or run backward.
    task automatic test_debounce_edges();
        write_debounce(16'd0);
        // Same time stamp as the last change: zero held time is not enough.
        send_scan(20'h00001, 32'd22);
        send_scan(20'h00001, 32'd23);
        // Key 0 lets go while the last key goes down: report holds 20 only.
        send_scan(20'h80000, 32'd24);
        // Four keys down leave the last two slots empty.
        send_scan(20'h80025, 32'd25);
        // A time stamp that wraps to zero after a change at the top gives a held time of 1.
        send_scan(20'hFFFFF, 32'hFFFF_FFFF);
        send_scan(20'h0AAAA, 32'hFFFF_FFFF);
        send_scan(20'h00000, 32'h0000_0000);

        write_debounce(16'hFFFF);
        send_scan(20'h55555, 32'd65535);
        send_scan(20'h55555, 32'd65536);
        // Odd keys and keys 0 and 2 have waited long enough here, other even keys have not.
        send_scan(20'hAAAAA, 32'd131071);
        send_scan(20'hAAAAA, 32'd131072);
        send_scan(20'h00000, 32'hFFFF_FFF0);
        // Across the wrap: exactly the debounce time, then one more.
        send_scan(20'hFFFFF, 32'h0000_FFEF);
        send_scan(20'hFFFFF, 32'h0000_FFF0);
    endtask

    // Bouncing keys: mostly a few bits flip between scans, with time steps
    // that cluster around the debounce threshold, plus whole random scans,
    // empty and full matrices and the odd jump across the whole time range.
    task automatic test_random_scans(input int count, input logic [DEB_W-1:0] deb,
                                     input bit steady);
        int unsigned step;
        int          flips;
        write_debounce(deb);
        no_idle = steady;
        for (int n = 0; n < count; n++) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: step = $urandom_range(0, 3);
                4, 5, 6:    step = $urandom_range(0, 2 * deb + 2);
                7, 8:       step = deb + $urandom_range(0, 1);
                default:    step = $urandom();
            endcase
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: begin
                    flips = $urandom_range(1, 3);
                    repeat (flips) begin
                        raw_level[$urandom_range(0, NUM_KEYS - 1)] ^= 1'b1;
                    end
                end
                6, 7:    raw_level = RAW_W'($urandom());
                8:       raw_level = '0;
                default: raw_level = '1;
            endcase
            send_scan(raw_level, clock_ms + step);
        end
        no_idle = 1'b0;
    endtask

    // The receiver holds off for a long stretch while scans keep coming, so
    // the block fills up and stalls its input; then the sender waits for
    // every report before going on.
    task automatic test_backpressure();
        wait_drained();
        ready_hold = HOLD_CYCLES;
        no_idle    = 1'b1;
        for (int n = 0; n < 40; n++) begin
            raw_level = RAW_W'($urandom());
            send_scan(raw_level, clock_ms + $urandom_range(0, 20));
        end
        no_idle = 1'b0;
        wait_drained();
    endtask

    // Result side: random stalls, none in a steady phase, and a counted
    // hold-off when a test asks for one.
    always @(negedge aclk) begin
        if (ready_hold > 0) begin
            m_ready <= 1'b0;
            ready_hold = ready_hold - 1;
        end else if (no_idle) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Every accepted report is compared with the oldest prediction.
    always @(posedge aclk) begin : report_check
        kmdr_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_reports.size() == 0) begin
                failures++;
                if (failures <= MAX_SHOWN) begin
                    $display("Report with no scan waiting for it: %h", m_data);
                end
            end else begin
                want = pending_reports.pop_front();
                compare_field("debounced_down", 32'(want.debounced_down),
                              32'(m_data.debounced_down));
                compare_field("any_down", 32'(want.any_down), 32'(m_data.any_down));
                compare_field("slot_0", 32'(want.slot_0), 32'(m_data.slot_0));
                compare_field("slot_1", 32'(want.slot_1), 32'(m_data.slot_1));
                compare_field("slot_2", 32'(want.slot_2), 32'(m_data.slot_2));
                compare_field("slot_3", 32'(want.slot_3), 32'(m_data.slot_3));
                compare_field("slot_4", 32'(want.slot_4), 32'(m_data.slot_4));
                compare_field("slot_5", 32'(want.slot_5), 32'(m_data.slot_5));
                reports_checked++;
            end
        end
    end

    // A hung handshake ends the run here.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Run stopped after %0d cycles with %0d reports outstanding.",
                     cycle_count, pending_reports.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        m_ready   = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        no_idle   = 1'b0;
        ready_hold      = 0;
        failures        = 0;
        scans_sent      = 0;
        reports_checked = 0;
        cycle_count     = 0;
        clock_ms        = '0;
        raw_level       = '0;
        debounce_setting = DEBOUNCE_RESET;
        for (int k = 0; k < NUM_KEYS; k++) begin
            key_down[k]   = 1'b0;
            changed_at[k] = '0;
        end
        steady_deb = DEB_W'($urandom_range(1, 40));

        // Reset is released on a falling edge.
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_defaults();
        test_debounce_edges();
        test_random_scans(100, 16'd10, 1'b0);
        test_random_scans(80, 16'd0, 1'b0);
        test_random_scans(80, 16'hFFFF, 1'b0);
        // A long stretch in which neither side ever idles.
        test_random_scans(100, steady_deb, 1'b1);
        test_backpressure();

        // The result register sits behind the input register; after draining, keep
        // running in case anything unexpected is still on its way.
        wait_drained();
        repeat (10) @(posedge aclk);

        $display("Checked %0d reports for %0d scans: reset defaults, threshold edges,",
                 reports_checked, scans_sent);
        $display("time wrap, bouncing keys at debounce 0, 10, %0d and 65535, output stall.",
                 steady_deb);
        if (failures == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches in total.", failures);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/kmdr_pkg.sv
rtl/core/kmdr_key_cell.sv
rtl/core/kmdr_report.sv
rtl/core/key_matrix_debounce_report_top.sv
tb/sv/testbench.sv
